// ===== rtl/hsfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and the CRC-8 byte update for the humidity sensor
// frame decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

	// crc-8, polynomial x^8+x^5+x^4+1, no reflection, no final xor
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// positions of the bytes inside one six-byte frame
	localparam logic [2:0] POS_TEMP_HI  = 3'd0;
	localparam logic [2:0] POS_TEMP_LO  = 3'd1;
	localparam logic [2:0] POS_TEMP_CRC = 3'd2;
	localparam logic [2:0] POS_HUM_HI   = 3'd3;
	localparam logic [2:0] POS_HUM_LO   = 3'd4;
	localparam logic [2:0] POS_HUM_CRC  = 3'd5;

	// conversion to hundredths: floor(span*raw/65536), minus the offset for temperature
	localparam int unsigned TEMP_SPAN   = 17500;
	localparam int unsigned TEMP_OFFSET = 4500;
	localparam int unsigned HUM_SPAN    = 10000;
	localparam int unsigned HUM_MAX     = 9999;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_TEMP_BAD = 2'd1,
		STATUS_HUM_BAD  = 2'd2
	} status_t;

	// raw words of one finished frame, handed to the scaling stage
	typedef struct packed {
		status_t     status;
		logic [15:0] temp_raw;
		logic [15:0] hum_raw;
	} frame_result_t;

	// one byte through the crc register, msb first
	function automatic logic [7:0] crc_add_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/hsfd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_byte_if / hsfd_result_if
// Valid/ready channels of the decoder: received bytes in, decoded results out.
// ----------------------------------------------------------------------------
interface hsfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       frame_start;

	modport source (output valid, output byte_value, output frame_start, input ready);
	modport sink   (input valid, input byte_value, input frame_start, output ready);
endinterface

interface hsfd_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;

	modport source (output valid, output status, output temperature_centi,
		output humidity_centi, input ready);
	modport sink   (input valid, input status, input temperature_centi,
		input humidity_centi, output ready);
endinterface
`default_nettype wire

// ===== rtl/hsfd_frame.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_frame
// Frame tracker: follows the byte position, runs the crc of each word, keeps
// the raw words and registers one raw result at the end of every frame.
// ----------------------------------------------------------------------------
module hsfd_frame (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	hsfd_byte_if.sink                    byte_ch,
	output hsfd_pkg::frame_result_t      done_s1,
	output logic                         done_valid_s1,
	input  wire logic                    done_ready
);

	logic [2:0]  byte_pos_q;
	logic [7:0]  crc_q;
	logic [7:0]  high_q;
	logic [15:0] temp_raw_q;
	logic        temp_good_q;
	logic [15:0] hum_raw_q;

	logic [2:0]  byte_pos_d;
	logic [7:0]  crc_d;
	logic [7:0]  high_d;
	logic [15:0] temp_raw_d;
	logic        temp_good_d;
	logic [15:0] hum_raw_d;

	logic        accept;
	logic [2:0]  pos_eff;
	logic [7:0]  crc_eff;
	logic [7:0]  crc_add;
	logic        emit;
	hsfd_pkg::status_t emit_status;

	// a stalled result blocks new bytes only while it cannot move on
	assign byte_ch.ready = !done_valid_s1 || done_ready;
	assign accept        = byte_ch.valid && byte_ch.ready;

	// start flag restarts position and crc before the byte is used
	always_comb begin
		if (byte_ch.frame_start || byte_pos_q > hsfd_pkg::POS_HUM_CRC) begin
			pos_eff = hsfd_pkg::POS_TEMP_HI;
		end else begin
			pos_eff = byte_pos_q;
		end
		crc_eff = byte_ch.frame_start ? hsfd_pkg::CRC_INIT : crc_q;
		crc_add = hsfd_pkg::crc_add_byte(crc_eff, byte_ch.byte_value);
	end

	// next state per byte position
	always_comb begin
		byte_pos_d  = byte_pos_q;
		crc_d       = crc_q;
		high_d      = high_q;
		temp_raw_d  = temp_raw_q;
		temp_good_d = temp_good_q;
		hum_raw_d   = hum_raw_q;
		emit        = 1'b0;
		emit_status = hsfd_pkg::STATUS_OK;
		case (pos_eff)
			hsfd_pkg::POS_TEMP_HI, hsfd_pkg::POS_HUM_HI: begin
				crc_d      = crc_add;
				high_d     = byte_ch.byte_value;
				byte_pos_d = pos_eff + 3'd1;
			end
			hsfd_pkg::POS_TEMP_LO: begin
				crc_d      = crc_add;
				temp_raw_d = {high_q, byte_ch.byte_value};
				byte_pos_d = hsfd_pkg::POS_TEMP_CRC;
			end
			hsfd_pkg::POS_TEMP_CRC: begin
				temp_good_d = (crc_eff == byte_ch.byte_value);
				crc_d       = hsfd_pkg::CRC_INIT;
				byte_pos_d  = hsfd_pkg::POS_HUM_HI;
			end
			hsfd_pkg::POS_HUM_LO: begin
				crc_d      = crc_add;
				hum_raw_d  = {high_q, byte_ch.byte_value};
				byte_pos_d = hsfd_pkg::POS_HUM_CRC;
			end
			hsfd_pkg::POS_HUM_CRC: begin
				crc_d      = hsfd_pkg::CRC_INIT;
				byte_pos_d = hsfd_pkg::POS_TEMP_HI;
				emit       = 1'b1;
				if (!temp_good_q) begin
					emit_status = hsfd_pkg::STATUS_TEMP_BAD;
				end else if (crc_eff != byte_ch.byte_value) begin
					emit_status = hsfd_pkg::STATUS_HUM_BAD;
				end else begin
					emit_status = hsfd_pkg::STATUS_OK;
				end
			end
			default: begin
				byte_pos_d = hsfd_pkg::POS_TEMP_HI;
			end
		endcase
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= hsfd_pkg::POS_TEMP_HI;
			crc_q       <= hsfd_pkg::CRC_INIT;
			high_q      <= '0;
			temp_raw_q  <= '0;
			temp_good_q <= 1'b0;
			hum_raw_q   <= '0;
		end else if (accept) begin
			byte_pos_q  <= byte_pos_d;
			crc_q       <= crc_d;
			high_q      <= high_d;
			temp_raw_q  <= temp_raw_d;
			temp_good_q <= temp_good_d;
			hum_raw_q   <= hum_raw_d;
		end
	end

	// raw result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_valid_s1 <= 1'b0;
		end else if (accept && emit) begin
			done_valid_s1 <= 1'b1;
		end else if (done_ready) begin
			done_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			done_s1.status   <= emit_status;
			done_s1.temp_raw <= temp_raw_q;
			done_s1.hum_raw  <= hum_raw_q;
		end
	end

	// position never leaves the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= hsfd_pkg::POS_HUM_CRC)
		else $error("frame position out of range");

	// crc register is fresh at the start of each word
	assert property (@(posedge clk) disable iff (!arst_n)
		(byte_pos_q == hsfd_pkg::POS_TEMP_HI || byte_pos_q == hsfd_pkg::POS_HUM_HI)
		|-> crc_q == hsfd_pkg::CRC_INIT)
		else $error("crc not restarted at word start");

	// a new raw result only follows an accepted humidity crc byte
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_valid_s1) |-> $past(accept && pos_eff == hsfd_pkg::POS_HUM_CRC))
		else $error("raw result without closing byte");

endmodule
`default_nettype wire

// ===== rtl/hsfd_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_scale
// Result stage: scales the raw words to hundredths, applies the crc status and
// holds the item in the output register.
// ----------------------------------------------------------------------------
module hsfd_scale (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  hsfd_pkg::frame_result_t done_s1,
	input  wire logic               done_valid_s1,
	output logic                    done_ready,
	hsfd_result_if.source           result_ch
);

	logic [30:0]        temp_prod;
	logic [14:0]        temp_scaled;
	logic signed [14:0] temp_centi;
	logic [29:0]        hum_prod;
	logic [13:0]        hum_centi;
	logic               take;

	assign done_ready = !result_ch.valid || result_ch.ready;
	assign take       = done_valid_s1 && done_ready;

	// fixed-point conversion, one constant multiply each
	always_comb begin
		temp_prod   = 31'(hsfd_pkg::TEMP_SPAN) * 31'(done_s1.temp_raw);
		temp_scaled = temp_prod[30:16];
		temp_centi  = signed'(15'(temp_scaled - 15'(hsfd_pkg::TEMP_OFFSET)));
		hum_prod    = 30'(hsfd_pkg::HUM_SPAN) * 30'(done_s1.hum_raw);
		hum_centi   = hum_prod[29:16];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.valid <= 1'b0;
		end else if (done_ready) begin
			result_ch.valid <= done_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_ch.status <= done_s1.status;
			case (done_s1.status)
				hsfd_pkg::STATUS_TEMP_BAD: begin
					result_ch.temperature_centi <= '0;
					result_ch.humidity_centi    <= '0;
				end
				hsfd_pkg::STATUS_HUM_BAD: begin
					result_ch.temperature_centi <= temp_centi;
					result_ch.humidity_centi    <= '0;
				end
				default: begin
					result_ch.temperature_centi <= temp_centi;
					result_ch.humidity_centi    <= hum_centi;
				end
			endcase
		end
	end

	// bad temperature crc reports nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.status == hsfd_pkg::STATUS_TEMP_BAD
		|-> result_ch.temperature_centi == 15'sd0 && result_ch.humidity_centi == 14'd0)
		else $error("values reported with bad temperature crc");

	// humidity only with a fully good frame
	assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.status != hsfd_pkg::STATUS_OK
		|-> result_ch.humidity_centi == 14'd0)
		else $error("humidity reported with crc error");

	// scaled humidity stays below full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> result_ch.humidity_centi <= 14'(hsfd_pkg::HUM_MAX))
		else $error("humidity out of range");

endmodule
`default_nettype wire

// ===== rtl/humidity_sensor_frame_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder
// Decodes six-byte temperature/humidity readouts with crc-8 checking.
// ----------------------------------------------------------------------------
// Bytes enter on byte_ch at up to one item per clock: temperature high, low,
// crc, then humidity high, low, crc. A set frame_start makes the byte the
// first of a new frame and drops any partial frame. Each word is checked with
// crc-8 (poly 0x31, init 0xFF). After the sixth byte one item passes the
// frame register, then the scaling and output register, to result_ch:
// status 0 ok, 1 temperature crc bad (both values zero), 2 humidity crc bad
// (humidity zero), temperature in hundredths of a degree and humidity in
// hundredths of a percent. A byte is taken every cycle unless a result is
// stalled at the output with another raw result behind it.
module humidity_sensor_frame_decoder (
	input  wire logic     clk,
	input  wire logic     arst_n,
	hsfd_byte_if.sink     byte_ch,
	hsfd_result_if.source result_ch
);

	hsfd_pkg::frame_result_t done_s1;
	logic                    done_valid_s1;
	logic                    done_ready;

	// byte tracking and crc check
	hsfd_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_ch       (byte_ch),
		.done_s1       (done_s1),
		.done_valid_s1 (done_valid_s1),
		.done_ready    (done_ready)
	);

	// scaling and output register
	hsfd_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.done_s1       (done_s1),
		.done_valid_s1 (done_valid_s1),
		.done_ready    (done_ready),
		.result_ch     (result_ch)
	);

endmodule
`default_nettype wire
